// File: rtl/core/hrsp_pkg.sv
// Shared types, codes and character tables for the response stream parser.
`default_nettype none

package hrsp_pkg;

    // Default width of the body length count
    localparam int LENGTH_BITS_DEF = 16;

    // Parse phase codes
    localparam logic [2:0] PH_PRE    = 3'd0;
    localparam logic [2:0] PH_STATUS = 3'd1;
    localparam logic [2:0] PH_HSTART = 3'd2;
    localparam logic [2:0] PH_NAME   = 3'd3;
    localparam logic [2:0] PH_SPACES = 3'd4;
    localparam logic [2:0] PH_VALUE  = 3'd5;
    localparam logic [2:0] PH_BODY   = 3'd6;

    // Byte kind tags
    localparam logic [2:0] KIND_SKIP   = 3'd0;
    localparam logic [2:0] KIND_STATUS = 3'd1;
    localparam logic [2:0] KIND_NAME   = 3'd2;
    localparam logic [2:0] KIND_VALUE  = 3'd3;
    localparam logic [2:0] KIND_BODY   = 3'd4;

    // Characters of interest
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // Length of the header name that carries the body length
    localparam logic [3:0] NAME_LEN = 4'd14;

    // Line-end flags of one result
    typedef struct packed {
        logic status_line_end;
        logic header_line_end;
        logic headers_end;
        logic message_end;
    } hrsp_flags_t;

    // Fold upper-case ASCII letters to lower case
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= CH_UC_A && c <= CH_UC_Z)
            return c + CASE_GAP;
        else
            return c;
    endfunction

    // "content-length", lower case, one character per position
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h6C; // l
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/http_response_stream_parser_core.sv
// Top level of the response stream parser: input register, parse step, result register.
//
// Usage:
//   Bytes of an HTTP-style response enter on stream_byte with in_valid/in_ready.
//   Every byte gives exactly one result on out_valid/out_ready: the byte itself,
//   its kind tag, the four line-end flags and the body length after the byte.
// Order: a transferred byte is held in the input register, parsed combinationally
//   once the result register has room, and then loaded into the result register,
//   which shows it on the result port until the output transfer takes it.
// Throughput: one byte per cycle while out_ready stays high; the parse step is a
//   single shallow update of the phase, name match, decimal accumulator and body
//   counter, all combinational between the input register and the result register.
// Stall: while the receiver holds out_ready low, the result register keeps its
//   transfer, the input register keeps one more byte, and in_ready then falls.
//   No byte is lost or repeated.
// Reset: rst_n clears both registers to empty and the parser to awaiting a
//   status line with a zero body length.
`default_nettype none

module http_response_stream_parser_core
    import hrsp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             stream_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [7:0]                  out_byte,
    output logic [2:0]                  byte_kind,
    output logic                        status_line_end,
    output logic                        header_line_end,
    output logic                        headers_end,
    output logic                        message_end,
    output logic [LENGTH_BITS-1:0]      body_length
);

    logic                   held_valid;
    logic [7:0]             held_byte;
    logic                   out_free;
    logic                   step;
    logic [2:0]             res_kind;
    hrsp_flags_t            res_flags;
    hrsp_flags_t            out_flags;
    logic [LENGTH_BITS-1:0] res_length;

    // A byte is parsed when it is held and the result register has room
    assign step = held_valid && out_free;

    hrsp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stream_byte (stream_byte),
        .take        (step),
        .held_valid  (held_valid),
        .held_byte   (held_byte)
    );

    hrsp_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .c      (held_byte),
        .kind   (res_kind),
        .flags  (res_flags),
        .length (res_length)
    );

    hrsp_out_stage #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step),
        .res_byte    (held_byte),
        .res_kind    (res_kind),
        .res_flags   (res_flags),
        .res_length  (res_length),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .free        (out_free),
        .out_byte    (out_byte),
        .byte_kind   (byte_kind),
        .out_flags   (out_flags),
        .body_length (body_length)
    );

    assign status_line_end = out_flags.status_line_end;
    assign header_line_end = out_flags.header_line_end;
    assign headers_end     = out_flags.headers_end;
    assign message_end     = out_flags.message_end;

endmodule

`default_nettype wire

// File: rtl/core/hrsp_in_stage.sv
// Input register: holds one accepted byte until the parser step takes it.
`default_nettype none

module hrsp_in_stage
    import hrsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] stream_byte,
    input  wire logic       take,
    output logic            held_valid,
    output logic [7:0]      held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Room when empty or when the held byte leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= stream_byte;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

// File: rtl/core/hrsp_parser.sv
// Per-byte parse step: line state, name match, length accumulation, body count.
`default_nettype none

module hrsp_parser
    import hrsp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [7:0]             c,
    output logic [2:0]                  kind,
    output hrsp_flags_t                 flags,
    output logic [LENGTH_BITS-1:0]      length
);

    localparam int WIDE_BITS = LENGTH_BITS + 4;

    logic [2:0]             phase_reg,  phase_next;
    logic                   cr_reg,     cr_next;
    logic [3:0]             pos_reg,    pos_next;
    logic                   match_reg,  match_next;
    logic [LENGTH_BITS-1:0] acc_reg,    acc_next;
    logic                   open_reg,   open_next;
    logic [LENGTH_BITS-1:0] rem_reg,    rem_next;

    logic                   match_hs;
    logic [LENGTH_BITS-1:0] rem_dec;

    // acc * 10 + digit, saturating at all ones
    function automatic logic [LENGTH_BITS-1:0] acc_step(
        input logic [LENGTH_BITS-1:0] acc,
        input logic [7:0]             ch
    );
        logic [WIDE_BITS-1:0] ext;
        logic [WIDE_BITS-1:0] sum;
        logic [7:0]           diff;
        diff = ch - CH_ZERO;
        ext  = {4'b0000, acc};
        sum  = (ext << 3) + (ext << 1) + {{LENGTH_BITS{1'b0}}, diff[3:0]};
        if (|sum[WIDE_BITS-1:LENGTH_BITS])
            return '1;
        else
            return sum[LENGTH_BITS-1:0];
    endfunction

    // One name character against the target; returns {pos, match}
    function automatic logic [4:0] name_step(
        input logic [7:0] ch,
        input logic [3:0] pos,
        input logic       m
    );
        if (m && pos < NAME_LEN && to_lower(ch) == name_char(pos))
            return {pos + 4'd1, 1'b1};
        else
            return {pos, 1'b0};
    endfunction

    assign rem_dec = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;

    // Next state and result of the current byte
    always_comb
    begin
        phase_next = phase_reg;
        cr_next    = cr_reg;
        pos_next   = pos_reg;
        match_next = match_reg;
        acc_next   = acc_reg;
        open_next  = open_reg;
        rem_next   = rem_reg;
        kind       = KIND_SKIP;
        flags      = '0;
        match_hs   = cr_reg ? 1'b0 : match_reg;

        unique case (phase_reg) inside
            PH_STATUS:
            begin
                if (c == CH_LF)
                begin
                    flags.status_line_end = 1'b1;
                    phase_next = PH_HSTART;
                    cr_next = 1'b0; pos_next = '0; match_next = 1'b1;
                    acc_next = '0;  open_next = 1'b1;
                end
                else if (c != CH_CR)
                    kind = KIND_STATUS;
            end
            PH_HSTART:
            begin
                if (c == CH_LF)
                begin
                    if (cr_reg)
                    begin
                        flags.headers_end = 1'b1;
                        if (rem_reg != '0)
                            phase_next = PH_BODY;
                        else
                        begin
                            flags.message_end = 1'b1;
                            phase_next = PH_PRE;
                        end
                    end
                    cr_next = 1'b0; pos_next = '0; match_next = 1'b1;
                    acc_next = '0;  open_next = 1'b1;
                end
                else if (c == CH_CR && !cr_reg)
                    cr_next = 1'b1;
                else
                begin
                    cr_next = 1'b0;
                    if (c == CH_COLON)
                    begin
                        match_next = 1'b0;
                        phase_next = PH_SPACES;
                    end
                    else if (c == CH_CR)
                    begin
                        // lone CR then CR: line starts, name cannot match
                        match_next = 1'b0;
                        cr_next    = 1'b1;
                        phase_next = PH_NAME;
                    end
                    else
                    begin
                        kind = KIND_NAME;
                        {pos_next, match_next} = name_step(c, pos_reg, match_hs);
                        phase_next = PH_NAME;
                    end
                end
            end
            PH_NAME:
            begin
                if (c == CH_LF)
                begin
                    // no colon: line dropped
                    phase_next = PH_HSTART;
                    cr_next = 1'b0; pos_next = '0; match_next = 1'b1;
                    acc_next = '0;  open_next = 1'b1;
                end
                else if (c == CH_COLON)
                begin
                    match_next = match_reg && (pos_reg == NAME_LEN);
                    cr_next    = 1'b0;
                    phase_next = PH_SPACES;
                end
                else if (c == CH_CR)
                begin
                    match_next = 1'b0;
                    cr_next    = 1'b1;
                end
                else
                begin
                    kind    = KIND_NAME;
                    cr_next = 1'b0;
                    {pos_next, match_next} = name_step(c, pos_reg, match_reg);
                end
            end
            PH_SPACES, PH_VALUE:
            begin
                if (c == CH_LF)
                begin
                    if (cr_reg)
                    begin
                        flags.header_line_end = 1'b1;
                        if (match_reg)
                            rem_next = acc_reg;
                    end
                    phase_next = PH_HSTART;
                    cr_next = 1'b0; pos_next = '0; match_next = 1'b1;
                    acc_next = '0;  open_next = 1'b1;
                end
                else if (c == CH_CR)
                begin
                    cr_next    = 1'b1;
                    open_next  = 1'b0;
                    phase_next = PH_VALUE;
                end
                else
                begin
                    cr_next = 1'b0;
                    if (!(phase_reg == PH_SPACES && c == CH_SPACE))
                    begin
                        kind       = KIND_VALUE;
                        phase_next = PH_VALUE;
                        if (open_reg && c >= CH_ZERO && c <= CH_NINE)
                            acc_next = acc_step(acc_reg, c);
                        else
                            open_next = 1'b0;
                    end
                end
            end
            PH_BODY:
            begin
                kind     = KIND_BODY;
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    flags.message_end = 1'b1;
                    phase_next = PH_PRE;
                    cr_next = 1'b0; pos_next = '0; match_next = 1'b1;
                    acc_next = '0;  open_next = 1'b1;
                end
            end
            default:
            begin
                // waiting for the status line; unused code behaves the same
                if (c == CH_LF)
                begin
                    phase_next = PH_PRE;
                    cr_next = 1'b0; pos_next = '0; match_next = 1'b1;
                    acc_next = '0;  open_next = 1'b1;
                end
                else if (c == CH_CR && !cr_reg)
                begin
                    cr_next    = 1'b1;
                    phase_next = PH_PRE;
                end
                else
                begin
                    cr_next = 1'b0;
                    if (c != CH_CR)
                        kind = KIND_STATUS;
                    phase_next = PH_STATUS;
                end
            end
        endcase
    end

    assign length = rem_next;

    // State registers, updated once per byte taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PRE;
            cr_reg    <= 1'b0;
            pos_reg   <= '0;
            match_reg <= 1'b1;
            acc_reg   <= '0;
            open_reg  <= 1'b1;
            rem_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cr_reg    <= cr_next;
            pos_reg   <= pos_next;
            match_reg <= match_next;
            acc_reg   <= acc_next;
            open_reg  <= open_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/hrsp_out_stage.sv
// Result register: holds one tagged byte until the receiver takes it.
`default_nettype none

module hrsp_out_stage
    import hrsp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire logic [7:0]             res_byte,
    input  wire logic [2:0]             res_kind,
    input  wire hrsp_flags_t            res_flags,
    input  wire logic [LENGTH_BITS-1:0] res_length,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic                        free,
    output logic [7:0]                  out_byte,
    output logic [2:0]                  byte_kind,
    output hrsp_flags_t                 out_flags,
    output logic [LENGTH_BITS-1:0]      body_length
);

    logic                   valid_reg;
    logic [7:0]             byte_reg;
    logic [2:0]             kind_reg;
    hrsp_flags_t            flags_reg;
    logic [LENGTH_BITS-1:0] length_reg;

    // Free when empty or when the held result is taken this cycle
    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (free)
            valid_reg <= load;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= res_byte;
            kind_reg   <= res_kind;
            flags_reg  <= res_flags;
            length_reg <= res_length;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign byte_kind   = kind_reg;
    assign out_flags   = flags_reg;
    assign body_length = length_reg;

endmodule

`default_nettype wire

// File: rtl/core/hrsp_checker.sv
// Port-level checks on the response stream parser, bound to the top level.
`default_nettype none

module hrsp_checker
    import hrsp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [7:0]             out_byte,
    input wire logic [2:0]             byte_kind,
    input wire logic                   status_line_end,
    input wire logic                   header_line_end,
    input wire logic                   headers_end,
    input wire logic                   message_end,
    input wire logic [LENGTH_BITS-1:0] body_length
);

    // A stalled result keeps its byte
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("result changed while stalled");

    // Kind tag stays within its defined codes
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_kind <= KIND_BODY)
        else $error("byte kind out of range");

    // Status, header and headers-end flags are exclusive and only ever mark a line feed
    a_line_end_lf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status_line_end || header_line_end || headers_end)
        |-> $onehot({status_line_end, header_line_end, headers_end})
            && out_byte == CH_LF && byte_kind == KIND_SKIP)
        else $error("line-end flag on wrong byte");

    // Blank line with nothing declared closes the message at once
    a_empty_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && headers_end && body_length == '0 |-> message_end)
        else $error("empty body without message end");

endmodule

bind http_response_stream_parser_core hrsp_checker #(
    .LENGTH_BITS (LENGTH_BITS)
) u_hrsp_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .byte_kind       (byte_kind),
    .status_line_end (status_line_end),
    .header_line_end (header_line_end),
    .headers_end     (headers_end),
    .message_end     (message_end),
    .body_length     (body_length)
);

`default_nettype wire

// File: dv/hrsp_tag_check_pkg.sv
// Byte-tag predictor and result checker for the response stream parser testbench.
`timescale 1ns / 100ps

package hrsp_tag_check_pkg;

    import hrsp_pkg::*;

    localparam int LB = LENGTH_BITS_DEF;
    localparam logic [LB-1:0] LENGTH_SAT = {LB{1'b1}};
    localparam string LENGTH_NAME = "content-length";

    // One tagged byte as it leaves the parser
    typedef struct {
        logic [7:0]    data;
        logic [2:0]    kind;
        hrsp_flags_t   flags;
        logic [LB-1:0] length;
    } byte_tag_t;

    class byte_tag_checker;

        // Parser state as the block should hold it
        logic [2:0]    phase;
        logic          cr_seen;
        logic [3:0]    match_pos;
        logic          name_ok;
        logic [LB-1:0] digits;
        logic          digits_open;
        logic [LB-1:0] body_left;

        byte_tag_t     tag_queue[$];
        int unsigned   mismatches;
        int unsigned   results_seen;

        function new();
            phase        = PH_PRE;
            body_left    = '0;
            mismatches   = 0;
            results_seen = 0;
            start_line();
        endfunction

        function void start_line();
            cr_seen     = 1'b0;
            match_pos   = '0;
            name_ok     = 1'b1;
            digits      = '0;
            digits_open = 1'b1;
        endfunction

        // Case-blind comparison against the length header name
        function void match_char(logic [7:0] c);
            logic [7:0] lc;
            lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
            if (name_ok && match_pos < NAME_LEN && lc == LENGTH_NAME[match_pos])
                match_pos++;
            else
                name_ok = 1'b0;
        endfunction

        // Saturating decimal accumulation, closed by the first non-digit
        function void value_char(logic [7:0] c);
            logic [63:0] v;
            if (digits_open && c >= CH_ZERO && c <= CH_NINE)
            begin
                v = 64'(digits) * 64'd10 + 64'(c - CH_ZERO);
                digits = (v > 64'(LENGTH_SAT)) ? LENGTH_SAT : v[LB-1:0];
            end
            else
            begin
                digits_open = 1'b0;
            end
        endfunction

        // Tag one byte and advance the parser state
        function byte_tag_t tag_byte(logic [7:0] c);
            byte_tag_t t;
            t.data  = c;
            t.kind  = KIND_SKIP;
            t.flags = '0;
            case (phase)
                PH_STATUS:
                begin
                    if (c == CH_LF)
                    begin
                        t.flags.status_line_end = 1'b1;
                        phase = PH_HSTART;
                        start_line();
                    end
                    else if (c != CH_CR)
                    begin
                        t.kind = KIND_STATUS;
                    end
                end
                PH_HSTART:
                begin
                    if (c == CH_LF)
                    begin
                        // only CR LF ends the headers; a bare LF is a skipped line
                        if (cr_seen)
                        begin
                            t.flags.headers_end = 1'b1;
                            if (body_left != 0)
                            begin
                                phase = PH_BODY;
                            end
                            else
                            begin
                                t.flags.message_end = 1'b1;
                                phase = PH_PRE;
                            end
                        end
                        start_line();
                    end
                    else if (c == CH_CR && !cr_seen)
                    begin
                        cr_seen = 1'b1;
                    end
                    else
                    begin
                        // lone CR at line start spoils the name match
                        if (cr_seen)
                            name_ok = 1'b0;
                        cr_seen = 1'b0;
                        if (c == CH_COLON)
                        begin
                            name_ok = 1'b0;
                            phase = PH_SPACES;
                        end
                        else if (c == CH_CR)
                        begin
                            name_ok = 1'b0;
                            cr_seen = 1'b1;
                            phase = PH_NAME;
                        end
                        else
                        begin
                            t.kind = KIND_NAME;
                            match_char(c);
                            phase = PH_NAME;
                        end
                    end
                end
                PH_NAME:
                begin
                    if (c == CH_LF)
                    begin
                        phase = PH_HSTART;
                        start_line();
                    end
                    else if (c == CH_COLON)
                    begin
                        name_ok = name_ok && match_pos == NAME_LEN;
                        cr_seen = 1'b0;
                        phase = PH_SPACES;
                    end
                    else if (c == CH_CR)
                    begin
                        name_ok = 1'b0;
                        cr_seen = 1'b1;
                    end
                    else
                    begin
                        t.kind = KIND_NAME;
                        cr_seen = 1'b0;
                        match_char(c);
                    end
                end
                PH_SPACES, PH_VALUE:
                begin
                    if (c == CH_LF)
                    begin
                        if (cr_seen)
                        begin
                            t.flags.header_line_end = 1'b1;
                            if (name_ok)
                                body_left = digits;
                        end
                        phase = PH_HSTART;
                        start_line();
                    end
                    else if (c == CH_CR)
                    begin
                        cr_seen = 1'b1;
                        digits_open = 1'b0;
                        phase = PH_VALUE;
                    end
                    else
                    begin
                        cr_seen = 1'b0;
                        if (!(phase == PH_SPACES && c == CH_SPACE))
                        begin
                            t.kind = KIND_VALUE;
                            value_char(c);
                            phase = PH_VALUE;
                        end
                    end
                end
                PH_BODY:
                begin
                    t.kind = KIND_BODY;
                    if (body_left != 0)
                        body_left--;
                    if (body_left == 0)
                    begin
                        t.flags.message_end = 1'b1;
                        phase = PH_PRE;
                        start_line();
                    end
                end
                default:
                begin
                    // ahead of the status line; empty CR LF lines are skipped
                    if (c == CH_LF)
                    begin
                        start_line();
                        phase = PH_PRE;
                    end
                    else if (c == CH_CR && !cr_seen)
                    begin
                        cr_seen = 1'b1;
                        phase = PH_PRE;
                    end
                    else
                    begin
                        cr_seen = 1'b0;
                        if (c != CH_CR)
                            t.kind = KIND_STATUS;
                        phase = PH_STATUS;
                    end
                end
            endcase
            t.length = body_left;
            return t;
        endfunction

        // Accepted input transfer: queue the tag the block owes for it
        function void note_byte(logic [7:0] c);
            tag_queue.push_back(tag_byte(c));
        endfunction

        function bit in_body();
            return phase == PH_BODY;
        endfunction

        function int unsigned pending();
            return tag_queue.size();
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            $display("result %0d: %s is 0x%0h, expected 0x%0h",
                     results_seen, field, got, want);
            mismatches++;
        endtask

        // Accepted output transfer: compare against the oldest tag
        task check_tag(byte_tag_t got);
            byte_tag_t want;
            if (tag_queue.size() == 0)
            begin
                report("unexpected result, out_byte", 32'(got.data), 32'hFFFF_FFFF);
                results_seen++;
                return;
            end
            want = tag_queue.pop_front();
            if (got.data !== want.data)
                report("out_byte", 32'(got.data), 32'(want.data));
            if (got.kind !== want.kind)
                report("byte_kind", 32'(got.kind), 32'(want.kind));
            if (got.flags.status_line_end !== want.flags.status_line_end)
                report("status_line_end", 32'(got.flags.status_line_end),
                       32'(want.flags.status_line_end));
            if (got.flags.header_line_end !== want.flags.header_line_end)
                report("header_line_end", 32'(got.flags.header_line_end),
                       32'(want.flags.header_line_end));
            if (got.flags.headers_end !== want.flags.headers_end)
                report("headers_end", 32'(got.flags.headers_end),
                       32'(want.flags.headers_end));
            if (got.flags.message_end !== want.flags.message_end)
                report("message_end", 32'(got.flags.message_end),
                       32'(want.flags.message_end));
            if (got.length !== want.length)
                report("body_length", 32'(got.length), 32'(want.length));
            results_seen++;
        endtask

    endclass

endpackage

// File: dv/http_response_stream_parser_core_test.sv
// Top-level testbench of the response stream parser: stimulus, stalls and result checks.
`timescale 1ns / 100ps

module http_response_stream_parser_core_test;

    import hrsp_pkg::*;
    import hrsp_tag_check_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int BYTE_TARGET = 650;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [7:0]    stream_byte;
    logic          out_valid;
    logic          out_ready;
    logic [7:0]    out_byte;
    logic [2:0]    byte_kind;
    logic          status_line_end;
    logic          header_line_end;
    logic          headers_end;
    logic          message_end;
    logic [LB-1:0] body_length;

    byte_tag_checker tags;
    logic [7:0]      byte_plan[$];
    int unsigned     bytes_sent;
    bit              quiet;

    http_response_stream_parser_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .stream_byte     (stream_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_byte        (out_byte),
        .byte_kind       (byte_kind),
        .status_line_end (status_line_end),
        .header_line_end (header_line_end),
        .headers_end     (headers_end),
        .message_end     (message_end),
        .body_length     (body_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned idle_cycles();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: check each output transfer, stall at random
    initial
    begin : receiver
        int unsigned hold;
        byte_tag_t   got;
        out_ready = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.data                  = out_byte;
                got.kind                  = byte_kind;
                got.flags.status_line_end = status_line_end;
                got.flags.header_line_end = header_line_end;
                got.flags.headers_end     = headers_end;
                got.flags.message_end     = message_end;
                got.length                = body_length;
                tags.check_tag(got);
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                hold = idle_cycles();
            end
        end
    end

    // One input transfer; valid stays up across back-to-back bytes
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        tags.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_plan();
        while (byte_plan.size() != 0)
            send_byte(byte_plan.pop_front());
    endtask

    // Hold the sender off until every queued tag has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tags.pending() != 0);
    endtask

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            byte_plan.push_back(s[i]);
    endfunction

    function automatic void push_crlf();
        byte_plan.push_back(CH_CR);
        byte_plan.push_back(CH_LF);
    endfunction

    // Length header name in random letter case
    function automatic void push_length_name();
        logic [7:0] ch;
        for (int i = 0; i < NAME_LEN; i++)
        begin
            ch = LENGTH_NAME[i];
            if (ch >= "a" && ch <= "z" && $urandom_range(0, 1))
                ch = ch - 8'h20;
            byte_plan.push_back(ch);
        end
    endfunction

    // Name, colon, zero to three spaces and the given value text; line end left to caller
    function automatic void push_length_line(string value);
        push_length_name();
        byte_plan.push_back(CH_COLON);
        repeat ($urandom_range(0, 3)) byte_plan.push_back(CH_SPACE);
        push_text(value);
    endfunction

    // Small length value with the odd leading zero and malformed variants
    function automatic string small_length();
        string v;
        v = $sformatf("%0d", $urandom_range(0, 24));
        if ($urandom_range(0, 4) == 0)
            v = {"00", v};
        case ($urandom_range(0, 7))
            0:       v = {v, ";q"};
            1:       v = {v, " 9"};
            2:       v = {"\t", v};
            3:       v = {"+", v};
            4:       v = "";
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        return (ch == CH_LF) ? 8'h41 : ch;
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] ch;
        if ($urandom_range(0, 3) == 0)
            ch = 8'($urandom_range(0, 255));
        else
            ch = 8'($urandom_range(8'h41, 8'h7A));
        if (ch == CH_LF || ch == CH_CR || ch == CH_COLON)
            ch = 8'h2D;
        return ch;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        return (ch == CH_LF || ch == CH_CR) ? 8'h3A : ch;
    endfunction

    // One header line, well-formed or one of the awkward shapes
    function automatic void plan_header();
        case ($urandom_range(0, 10))
            0, 1, 2:
            begin
                push_length_line(small_length());
                push_crlf();
            end
            3:
            begin
                // large value at or near saturation, always overridden by a later small one
                case ($urandom_range(0, 2))
                    0:       push_length_line("65535");
                    1:       push_length_line("65536");
                    default: push_length_line($sformatf("%0d",
                                 $urandom_range(65530, 99999999)));
                endcase
                push_crlf();
                push_length_line(small_length());
                push_crlf();
            end
            4:
            begin
                repeat ($urandom_range(1, 8)) byte_plan.push_back(name_char());
                byte_plan.push_back(CH_COLON);
                repeat ($urandom_range(0, 2)) byte_plan.push_back(CH_SPACE);
                repeat ($urandom_range(0, 8)) byte_plan.push_back(value_char());
                if ($urandom_range(0, 3) == 0)
                    byte_plan.push_back(CH_CR);
                push_crlf();
            end
            5:
            begin
                // no colon: skipped line
                repeat ($urandom_range(1, 8)) byte_plan.push_back(name_char());
                push_crlf();
            end
            6:
            begin
                // value ended by a bare LF: no update
                push_length_line($sformatf("%0d", $urandom_range(0, 99999)));
                byte_plan.push_back(CH_LF);
            end
            7:
            begin
                byte_plan.push_back(CH_COLON);
                repeat ($urandom_range(0, 5)) byte_plan.push_back(value_char());
                push_crlf();
            end
            8:
            begin
                // CR inside the name
                push_text("Content");
                byte_plan.push_back(CH_CR);
                push_text("-Length: 6");
                push_crlf();
            end
            9:
            begin
                // lone CR, or two, at line start
                byte_plan.push_back(CH_CR);
                if ($urandom_range(0, 2) == 0)
                    byte_plan.push_back(CH_CR);
                push_length_line(small_length());
                push_crlf();
            end
            default:
            begin
                if ($urandom_range(0, 1))
                begin
                    byte_plan.push_back(CH_LF);
                end
                else
                begin
                    // near misses of the name
                    if ($urandom_range(0, 1))
                    begin
                        push_length_name();
                        push_text("s: 4");
                    end
                    else
                    begin
                        push_text("content-lengt: 4");
                    end
                    push_crlf();
                end
            end
        endcase
    endfunction

    function automatic void plan_message();
        int unsigned n;
        // empty lines ahead of the status line, sometimes a bare LF
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n)
        begin
            if ($urandom_range(0, 1))
                push_crlf();
            else
                byte_plan.push_back(CH_LF);
        end
        if ($urandom_range(0, 7) == 0)
            byte_plan.push_back(CH_CR);
        if ($urandom_range(0, 1))
            push_text("HTTP/1.1 200 OK");
        else
            repeat ($urandom_range(1, 10)) byte_plan.push_back(any_but_lf());
        push_crlf();
        repeat ($urandom_range(0, 4)) plan_header();
        // blank line, now and then left out to break the framing
        if ($urandom_range(0, 9) != 0)
            push_crlf();
    endfunction

    initial
    begin : stimulus
        tags        = new();
        quiet       = 1'b0;
        bytes_sent  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        stream_byte = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bare LF and empty line ahead, extreme bytes, short body
        byte_plan.push_back(CH_LF);
        push_crlf();
        byte_plan.push_back(8'hFF);
        byte_plan.push_back(8'h00);
        push_crlf();
        push_text("Content-length: 2");
        push_crlf();
        push_crlf();
        byte_plan.push_back(8'h00);
        byte_plan.push_back(8'hFF);
        send_plan();
        wait_drained();

        // Random messages with the odd burst of noise between them
        while (bytes_sent < BYTE_TARGET)
        begin
            if ($urandom_range(0, 5) == 0)
                wait_drained();
            quiet = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 6)) byte_plan.push_back(8'($urandom_range(0, 255)));
            plan_message();
            send_plan();
            while (tags.in_body())
                send_byte(8'($urandom_range(0, 255)));
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (tags.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/hrsp_pkg.sv
rtl/core/hrsp_in_stage.sv
rtl/core/hrsp_parser.sv
rtl/core/hrsp_out_stage.sv
rtl/core/http_response_stream_parser_core.sv
rtl/core/hrsp_checker.sv
dv/hrsp_tag_check_pkg.sv
dv/http_response_stream_parser_core_test.sv
